// ===== hw/rtl/huffman_bit_packing_encoder_unit_assert.svh =====
// assertion macros for the encoder's packer module
// each expects aclk and aresetn in scope
`ifndef HUFFMAN_BIT_PACKING_ENCODER_UNIT_ASSERT_SVH
`define HUFFMAN_BIT_PACKING_ENCODER_UNIT_ASSERT_SVH

// same-cycle implication
`define HBPE_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define HBPE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/hbpe_pkg.sv =====
`timescale 1ns / 1ps

package hbpe_pkg;

    localparam int SYMBOL_COUNT_DEF = 256;
    localparam int MAX_CODE_LEN_DEF = 32;

    localparam int SYM_FIELD_W = 8;
    localparam int LEN_W       = 6;
    localparam int CODE_W      = 32;
    localparam int BYTE_W      = 8;

    typedef enum logic [1:0] {
        REQ_LOAD     = 2'd0,
        REQ_ENCODE   = 2'd1,
        REQ_FLUSH    = 2'd2,
        REQ_RESERVED = 2'd3
    } req_t;

    // registered table read for the item in the work stage
    typedef struct packed {
        logic              hit;
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] bits;
    } lookup_t;

endpackage

// ===== hw/rtl/huffman_bit_packing_encoder_unit.sv =====
`timescale 1ns / 1ps

// Table-driven Huffman encoder, MSB-first byte packing.
// Input channel s_*: req_type load (write a code table entry), encode (look up
// symbol and append its code bits) or flush (emit the partial byte, zero padded).
// Result channel m_*: one packed byte per word; m_is_last marks the final word
// of an input item, m_unknown_symbol flags an encode of an unloaded symbol.
// The table read is registered as an item is accepted; the item is packed in the
// work stage once the output buffer is free, and its first word is then on m_*.
// Throughput: one item per cycle while each item makes at most one word and
// m_ready is high. An encode making more than one word holds the buffer until
// its last word is taken, so the next item waits in the work stage, s_ready low.
// Reset (aresetn low, synchronous): all table entries become unloaded, the
// pending bit buffer empties, no result is pending. Code memory contents are
// not cleared; an entry's stored code is used only after it is loaded.
// When m_ready is low the current word holds; one more item can sit in the
// work stage before s_ready goes low.
module huffman_bit_packing_encoder_unit #(
    parameter int SYMBOL_COUNT = hbpe_pkg::SYMBOL_COUNT_DEF,
    parameter int MAX_CODE_LEN = hbpe_pkg::MAX_CODE_LEN_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [1:0]                         s_req_type,
    input  logic [hbpe_pkg::SYM_FIELD_W-1:0]   s_symbol,
    input  logic [hbpe_pkg::LEN_W-1:0]         s_code_length,
    input  logic [hbpe_pkg::CODE_W-1:0]        s_code_value,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [hbpe_pkg::BYTE_W-1:0]        m_out_byte,
    output logic                               m_is_last,
    output logic                               m_unknown_symbol
);

    logic              accept;
    logic              load_en;
    hbpe_pkg::lookup_t lookup;

    assign accept  = s_valid && s_ready;
    assign load_en = accept && (s_req_type == hbpe_pkg::REQ_LOAD);

    hbpe_table #(
        .SYMBOL_COUNT (SYMBOL_COUNT),
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_table (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .wr_en       (load_en),
        .rd_en       (accept),
        .symbol      (s_symbol),
        .code_length (s_code_length),
        .code_value  (s_code_value),
        .lookup      (lookup)
    );

    hbpe_packer #(
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_packer (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_req_type       (s_req_type),
        .lookup           (lookup),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_byte       (m_out_byte),
        .m_is_last        (m_is_last),
        .m_unknown_symbol (m_unknown_symbol)
    );

endmodule

// ===== hw/rtl/hbpe_ram.sv =====
`timescale 1ns / 1ps

module hbpe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/hbpe_table.sv =====
`timescale 1ns / 1ps

module hbpe_table #(
    parameter int SYMBOL_COUNT = hbpe_pkg::SYMBOL_COUNT_DEF,
    parameter int MAX_CODE_LEN = hbpe_pkg::MAX_CODE_LEN_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               wr_en,
    input  logic                               rd_en,
    input  logic [hbpe_pkg::SYM_FIELD_W-1:0]   symbol,
    input  logic [hbpe_pkg::LEN_W-1:0]         code_length,
    input  logic [hbpe_pkg::CODE_W-1:0]        code_value,
    output hbpe_pkg::lookup_t                  lookup
);

    localparam int SYM_W   = $clog2(SYMBOL_COUNT);
    localparam int ENTRY_W = hbpe_pkg::LEN_W + hbpe_pkg::CODE_W;

    logic                          in_range;
    logic [SYM_W-1:0]              idx;
    logic [hbpe_pkg::LEN_W-1:0]    sat_len;
    logic [hbpe_pkg::CODE_W-1:0]   code_mask;
    logic [ENTRY_W-1:0]            wdata;
    logic [ENTRY_W-1:0]            rdata;
    logic                          valid_reg [SYMBOL_COUNT];
    logic                          hit_reg;

    assign in_range = {1'b0, symbol} < (hbpe_pkg::SYM_FIELD_W + 1)'(SYMBOL_COUNT);
    assign idx      = symbol[SYM_W-1:0];
    assign sat_len  = (code_length > hbpe_pkg::LEN_W'(MAX_CODE_LEN))
                    ? hbpe_pkg::LEN_W'(MAX_CODE_LEN) : code_length;

    // bits above the code length are stored as zero
    assign code_mask = (sat_len >= hbpe_pkg::LEN_W'(hbpe_pkg::CODE_W)) ? '1
                     : hbpe_pkg::CODE_W'((33'd1 << sat_len) - 33'd1);
    assign wdata = {sat_len, code_value & code_mask};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SYMBOL_COUNT; i++) begin
                valid_reg[i] <= 1'b0;
            end
        end else if (wr_en && in_range) begin
            valid_reg[idx] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            hit_reg <= in_range && valid_reg[idx];
        end
    end

    hbpe_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SYMBOL_COUNT)
    ) u_code_ram (
        .aclk  (aclk),
        .we    (wr_en && in_range),
        .re    (rd_en),
        .addr  (idx),
        .wdata (wdata),
        .rdata (rdata)
    );

    assign lookup.hit  = hit_reg;
    assign lookup.len  = rdata[ENTRY_W-1 -: hbpe_pkg::LEN_W];
    assign lookup.bits = rdata[hbpe_pkg::CODE_W-1:0];

endmodule

// ===== hw/rtl/hbpe_packer.sv =====
`timescale 1ns / 1ps

`include "huffman_bit_packing_encoder_unit_assert.svh"

module hbpe_packer #(
    parameter int MAX_CODE_LEN = hbpe_pkg::MAX_CODE_LEN_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_req_type,
    input  hbpe_pkg::lookup_t             lookup,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [hbpe_pkg::BYTE_W-1:0]   m_out_byte,
    output logic                          m_is_last,
    output logic                          m_unknown_symbol
);

    localparam int ACC_W = MAX_CODE_LEN + 7;
    // wide enough for the bit count and for the two-word compare
    localparam int POS_W = $clog2(ACC_W + 9);

    // work stage
    logic                 st1_valid_reg, st1_valid_next;
    hbpe_pkg::req_t       st1_req_reg;

    // bits waiting for a full byte
    logic [6:0]           pend_bits_reg, pend_bits_next;
    logic [2:0]           pend_cnt_reg, pend_cnt_next;

    // output buffer: words leave from the top of acc, pos bits still unsent
    logic [ACC_W-1:0]     acc_reg, acc_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic                 unk_reg, unk_next;

    logic                 buf_free;
    logic                 st1_adv;
    logic                 accept;
    logic [ACC_W+hbpe_pkg::CODE_W-1:0] bits_wide;
    logic [ACC_W-1:0]     enc_acc;
    logic [POS_W-1:0]     enc_total;
    logic [6:0]           enc_mask;
    logic [3:0]           flush_sh;
    logic [7:0]           flush_byte;
    logic [ACC_W-1:0]     out_shift;
    logic [6:0]           pend_mask;

    assign buf_free = (pos_reg < POS_W'(8)) || (m_ready && (pos_reg < POS_W'(16)));
    assign st1_adv  = st1_valid_reg && buf_free;
    assign s_ready  = !st1_valid_reg || buf_free;
    assign accept   = s_valid && s_ready;

    assign bits_wide = {{ACC_W{1'b0}}, lookup.bits};
    assign enc_acc   = (ACC_W'(pend_bits_reg) << lookup.len) | bits_wide[ACC_W-1:0];
    assign enc_total = POS_W'(pend_cnt_reg) + POS_W'(lookup.len);
    assign enc_mask  = 7'((8'd1 << enc_total[2:0]) - 8'd1);
    assign flush_sh  = 4'd8 - 4'(pend_cnt_reg);
    assign flush_byte = 8'({1'b0, pend_bits_reg} << flush_sh);

    always_comb begin
        st1_valid_next = st1_valid_reg;
        if (accept) begin
            st1_valid_next = 1'b1;
        end else if (st1_adv) begin
            st1_valid_next = 1'b0;
        end
    end

    always_comb begin
        pend_bits_next = pend_bits_reg;
        pend_cnt_next  = pend_cnt_reg;
        acc_next       = acc_reg;
        pos_next       = pos_reg;
        unk_next       = unk_reg;
        if (st1_adv) begin
            acc_next = '0;
            pos_next = '0;
            unk_next = 1'b0;
            case (st1_req_reg)
                hbpe_pkg::REQ_ENCODE: begin
                    if (!lookup.hit) begin
                        pos_next = POS_W'(8);
                        unk_next = 1'b1;
                    end else begin
                        acc_next       = enc_acc;
                        pos_next       = enc_total;
                        pend_cnt_next  = enc_total[2:0];
                        pend_bits_next = enc_acc[6:0] & enc_mask;
                    end
                end
                hbpe_pkg::REQ_FLUSH: begin
                    if (pend_cnt_reg != 3'd0) begin
                        acc_next = ACC_W'(flush_byte);
                        pos_next = POS_W'(8);
                    end
                    pend_bits_next = '0;
                    pend_cnt_next  = '0;
                end
                default: begin
                end
            endcase
        end else if (m_valid && m_ready) begin
            pos_next = pos_reg - POS_W'(8);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
            pend_bits_reg <= '0;
            pend_cnt_reg  <= '0;
            pos_reg       <= '0;
        end else begin
            st1_valid_reg <= st1_valid_next;
            pend_bits_reg <= pend_bits_next;
            pend_cnt_reg  <= pend_cnt_next;
            pos_reg       <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            st1_req_reg <= hbpe_pkg::req_t'(s_req_type);
        end
        acc_reg <= acc_next;
        unk_reg <= unk_next;
    end

    assign out_shift        = acc_reg >> (pos_reg - POS_W'(8));
    assign m_valid          = pos_reg >= POS_W'(8);
    assign m_out_byte       = out_shift[7:0];
    assign m_is_last        = pos_reg < POS_W'(16);
    assign m_unknown_symbol = unk_reg;

    assign pend_mask = 7'((8'd1 << pend_cnt_reg) - 8'd1);

    `HBPE_ASSERT_IMPL(a_pend_clean, 1'b1, (pend_bits_reg & ~pend_mask) == 7'd0, "stale pending bits")
    `HBPE_ASSERT_IMPL(a_unk_word, m_valid && m_unknown_symbol, m_out_byte == 8'd0 && m_is_last, "bad error word")
    `HBPE_ASSERT_NEXT(a_more_words, m_valid && m_ready && !m_is_last, m_valid, "lost following word")
    `HBPE_ASSERT_NEXT(a_st1_hold, st1_valid_reg && !s_ready, st1_valid_reg && $stable(st1_req_reg), "work stage dropped")

endmodule

// ===== verif/huffman_bit_packing_encoder_unit_tb.sv =====
`timescale 1ns / 1ps

typedef struct {
    logic [7:0] out_byte;
    logic       is_last;
    logic       unknown_symbol;
} packed_word_t;

class packing_scoreboard;
    localparam int SYMBOLS = hbpe_pkg::SYMBOL_COUNT_DEF;
    localparam int MAX_LEN = hbpe_pkg::MAX_CODE_LEN_DEF;

    bit           loaded    [SYMBOLS];
    bit [5:0]     code_len  [SYMBOLS];
    bit [31:0]    code_bits [SYMBOLS];
    bit [6:0]     held_bits;
    bit [2:0]     held_count;
    packed_word_t expected_bytes[$];
    int           mismatches;

    function bit [63:0] low_ones(int unsigned n);
        return (64'd1 << n) - 64'd1;
    endfunction

    task report_mismatch(string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // advance the packing state for one accepted input word
    function void note_request(logic [1:0] req, logic [7:0] sym, logic [5:0] len,
                               logic [31:0] val);
        bit [63:0]    acc;
        int unsigned  use_len;
        int unsigned  total;
        int           nbytes;
        packed_word_t w;
        case (req)
            hbpe_pkg::REQ_LOAD: begin
                use_len = (len > MAX_LEN) ? MAX_LEN : len;
                loaded[sym]    = 1'b1;
                code_len[sym]  = 6'(use_len);
                code_bits[sym] = 32'(val & low_ones(use_len));
            end
            hbpe_pkg::REQ_ENCODE: begin
                if (!loaded[sym]) begin
                    w.out_byte       = 8'h00;
                    w.is_last        = 1'b1;
                    w.unknown_symbol = 1'b1;
                    expected_bytes = {expected_bytes, w};
                end else begin
                    use_len = code_len[sym];
                    acc     = (64'(held_bits) << use_len) | 64'(code_bits[sym]);
                    total   = held_count + use_len;
                    nbytes  = int'(total / 8);
                    for (int i = 0; i < nbytes; i++) begin
                        total            = total - 8;
                        w.out_byte       = 8'(acc >> total);
                        w.is_last        = (i == nbytes - 1);
                        w.unknown_symbol = 1'b0;
                        expected_bytes = {expected_bytes, w};
                    end
                    held_count = 3'(total);
                    held_bits  = 7'(acc & low_ones(total));
                end
            end
            hbpe_pkg::REQ_FLUSH: begin
                if (held_count != 0) begin
                    w.out_byte       = 8'(8'(held_bits) << (8 - held_count));
                    w.is_last        = 1'b1;
                    w.unknown_symbol = 1'b0;
                    expected_bytes = {expected_bytes, w};
                    held_bits  = '0;
                    held_count = '0;
                end
            end
            default: begin
            end
        endcase
    endfunction

    task check_byte(logic [7:0] out_byte, logic is_last, logic unknown_symbol);
        packed_word_t w;
        if (expected_bytes.size() == 0) begin
            report_mismatch($sformatf("unexpected word byte=%02h", out_byte));
        end else begin
            w = expected_bytes.pop_front();
            if (out_byte !== w.out_byte)
                report_mismatch($sformatf("out_byte %02h, want %02h", out_byte, w.out_byte));
            if (is_last !== w.is_last)
                report_mismatch($sformatf("is_last %b, want %b", is_last, w.is_last));
            if (unknown_symbol !== w.unknown_symbol)
                report_mismatch($sformatf("unknown_symbol %b, want %b",
                                          unknown_symbol, w.unknown_symbol));
        end
    endtask
endclass

module huffman_bit_packing_encoder_unit_tb;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_req_type;
    logic [7:0]  s_symbol;
    logic [5:0]  s_code_length;
    logic [31:0] s_code_value;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_out_byte;
    logic        m_is_last;
    logic        m_unknown_symbol;

    packing_scoreboard sb = new();
    int                items_sent = 0;
    int                loaded_syms[$];

    huffman_bit_packing_encoder_unit dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_req_type       (s_req_type),
        .s_symbol         (s_symbol),
        .s_code_length    (s_code_length),
        .s_code_value     (s_code_value),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_byte       (m_out_byte),
        .m_is_last        (m_is_last),
        .m_unknown_symbol (m_unknown_symbol)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("[huffman_bit_packing_encoder_unit] ERROR");
        $finish;
    end

    task send_request(logic [1:0] req, logic [7:0] sym, logic [5:0] len, logic [31:0] val);
        int gap;
        gap = $urandom_range(0, 3);
        // bursts with s_valid held high between requests
        if (items_sent % 64 < 12)
            gap = 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_req_type    <= req;
        s_symbol      <= sym;
        s_code_length <= len;
        s_code_value  <= val;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(req, sym, len, val);
        items_sent++;
    endtask

    initial begin : result_sink
        int gap;
        int words_taken;
        words_taken = 0;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            gap = $urandom_range(0, 3);
            if (words_taken % 50 < 10)
                gap = 0;
            // long hold so the block backs up and stalls its input
            if (words_taken == 40)
                gap = 250;
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            sb.check_byte(m_out_byte, m_is_last, m_unknown_symbol);
            words_taken++;
        end
    end

    initial begin : stimulus
        int          pick;
        int          drain;
        logic [7:0]  sym;
        logic [5:0]  len;
        int          r;
        aresetn       <= 1'b0;
        s_valid       <= 1'b0;
        s_req_type    <= hbpe_pkg::REQ_LOAD;
        s_symbol      <= '0;
        s_code_length <= '0;
        s_code_value  <= '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty flush, unloaded symbol, unused request type
        send_request(hbpe_pkg::REQ_FLUSH, 8'h00, 6'd0, 32'h0);
        send_request(hbpe_pkg::REQ_ENCODE, 8'h00, 6'd0, 32'h0);
        send_request(hbpe_pkg::REQ_RESERVED, 8'hFF, 6'h3F, 32'hFFFF_FFFF);
        // zero-length code appends nothing
        send_request(hbpe_pkg::REQ_LOAD, 8'h00, 6'd0, 32'hFFFF_FFFF);
        send_request(hbpe_pkg::REQ_ENCODE, 8'h00, 6'd0, 32'h0);
        send_request(hbpe_pkg::REQ_LOAD, 8'hFF, 6'd32, 32'hFFFF_FFFF);
        send_request(hbpe_pkg::REQ_ENCODE, 8'hFF, 6'd0, 32'h0);
        // length above the max saturates
        send_request(hbpe_pkg::REQ_LOAD, 8'h01, 6'h3F, 32'h1234_5678);
        // bits above the length are dropped
        send_request(hbpe_pkg::REQ_LOAD, 8'h02, 6'd3, 32'hFFFF_FFFD);
        send_request(hbpe_pkg::REQ_ENCODE, 8'h02, 6'd0, 32'h0);
        send_request(hbpe_pkg::REQ_ENCODE, 8'h01, 6'd0, 32'h0);
        send_request(hbpe_pkg::REQ_FLUSH, 8'h00, 6'd0, 32'h0);
        send_request(hbpe_pkg::REQ_LOAD, 8'h80, 6'd33, 32'h8000_0001);
        send_request(hbpe_pkg::REQ_LOAD, 8'h03, 6'd1, 32'h0);
        repeat (7) send_request(hbpe_pkg::REQ_ENCODE, 8'h03, 6'd0, 32'h0);
        // seven bits pending plus a full-length code
        send_request(hbpe_pkg::REQ_ENCODE, 8'hFF, 6'd0, 32'h0);
        send_request(hbpe_pkg::REQ_ENCODE, 8'h80, 6'd0, 32'h0);
        send_request(hbpe_pkg::REQ_FLUSH, 8'h00, 6'd0, 32'h0);
        send_request(hbpe_pkg::REQ_FLUSH, 8'h00, 6'd0, 32'h0);
        loaded_syms = '{8'h00, 8'h01, 8'h02, 8'h03, 8'h80, 8'hFF};

        for (int i = 0; i < 310; i++) begin
            pick = $urandom_range(0, 99);
            r    = $urandom_range(0, 99);
            if (r < 5)
                len = 6'd0;
            else if (r < 70)
                len = 6'($urandom_range(1, 10));
            else if (r < 92)
                len = 6'($urandom_range(11, 32));
            else
                len = 6'($urandom_range(33, 63));
            if (pick < 18) begin
                sym = 8'($urandom_range(0, 255));
                loaded_syms = {loaded_syms, int'(sym)};
                send_request(hbpe_pkg::REQ_LOAD, sym, len, $urandom);
            end else if (pick < 83) begin
                if ($urandom_range(0, 9) == 0)
                    sym = 8'($urandom_range(0, 255));
                else
                    sym = 8'(loaded_syms[$urandom_range(0, loaded_syms.size() - 1)]);
                send_request(hbpe_pkg::REQ_ENCODE, sym, len, $urandom);
            end else if (pick < 95) begin
                send_request(hbpe_pkg::REQ_FLUSH, 8'($urandom_range(0, 255)), len, $urandom);
            end else begin
                send_request(hbpe_pkg::REQ_RESERVED, 8'($urandom_range(0, 255)), len,
                             $urandom);
            end
        end
        send_request(hbpe_pkg::REQ_FLUSH, 8'h00, 6'd0, 32'h0);
        s_valid <= 1'b0;

        drain = 0;
        while (sb.expected_bytes.size() != 0 && drain < 20000) begin
            @(posedge aclk);
            drain++;
        end
        repeat (20) @(posedge aclk);
        if (sb.expected_bytes.size() != 0)
            sb.report_mismatch($sformatf("%0d words never arrived", sb.expected_bytes.size()));
        if (sb.mismatches == 0) begin
            $display("[huffman_bit_packing_encoder_unit] OK");
        end else begin
            $display("[huffman_bit_packing_encoder_unit] ERROR");
        end
        $finish;
    end

endmodule
